/* design/pfla_pkg.sv */
// Page free-list allocator: shared types and constants.
// No dependencies; imported by page_free_list_allocator_top.
package pfla_pkg;

	localparam int PAGE_IDX_W = 10;
	localparam int COUNT_W    = 11;
	localparam int OFFSET_W   = 32;
	localparam int PSIZE_W    = 17;
	localparam int UHDR_W     = 16;
	localparam int FHDR_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_HDR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_HDR  = 2'd2;

	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 17'd4096;
	localparam logic [UHDR_W-1:0]  USER_HDR_RST  = 16'd0;
	localparam logic [FHDR_W-1:0]  FILE_HDR_RST  = 8'd32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ALREADY   = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_NO_SPACE  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

endpackage

/* design/page_free_list_allocator_top.sv */
// Page free-list allocator top level: LIFO free list linked through a page memory.
// Depends on pfla_pkg.
//
// Usage:
//   Request channel: mode/page_index are taken at a rising edge with start high
//   and busy low. mode 0 allocates (pop from free list, else grow the store),
//   mode 1 releases page_index (push onto the free list).
//   Result channel: done is high for exactly one cycle with status, result_page,
//   byte_offset, reused and the three page counts. The receiver cannot stall.
//   Config: cfg_we writes cfg_data into register cfg_index (0 page size,
//   1 user header size, 2 file header size); write only while idle.
// Timing:
//   A request has an accept step and an exec step: the accept edge registers the memory
//   read (head link or release target), the exec edge does the update and write-back.
//   busy is high for one cycle after accept, so no new request is taken until exec ends.
//   done and the result outputs are registered at the exec edge.
// Reset:
//   Counts clear, free list empty, config registers take their defaults.
//   No clearing pass: a page's memory entry is written when the store grows
//   onto it, and entries beyond the page count are never used.
module page_free_list_allocator_top #(
	parameter int MAX_PAGES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [pfla_pkg::PAGE_IDX_W-1:0]     page_index,
	input  logic                                cfg_we,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfla_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [pfla_pkg::PAGE_IDX_W-1:0]     result_page,
	output logic [pfla_pkg::OFFSET_W-1:0]       byte_offset,
	output logic                                reused,
	output logic [pfla_pkg::COUNT_W-1:0]        total_pages,
	output logic [pfla_pkg::COUNT_W-1:0]        freed_pages,
	output logic [pfla_pkg::COUNT_W-1:0]        live_pages
);
	import pfla_pkg::*;

	localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CW    = $clog2(MAX_PAGES + 1);
	localparam int OFFPW = (PW > PAGE_IDX_W) ? PW : PAGE_IDX_W;
	localparam int PRODW = OFFPW + PSIZE_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAGES);

	typedef struct packed {
		logic          del;
		logic [PW-1:0] link;
	} entry_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	entry_t mem [MAX_PAGES];

	state_t                state_q;
	logic [PSIZE_W-1:0]    page_size_q;
	logic [UHDR_W-1:0]     user_hdr_q;
	logic [FHDR_W-1:0]     file_hdr_q;
	logic [PW-1:0]         head_q;
	logic [CW-1:0]         free_cnt_q;
	logic [CW-1:0]         page_cnt_q;

	mode_t                 mode_s1;
	logic [PAGE_IDX_W-1:0] req_s1;
	entry_t                rdata_s1;

	logic                  done_q;
	status_t               status_q;
	logic [PAGE_IDX_W-1:0] page_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic                  reused_q;
	logic [COUNT_W-1:0]    total_q;
	logic [COUNT_W-1:0]    freed_q;
	logic [COUNT_W-1:0]    live_q;

	logic                  accept;
	logic [PW-1:0]         rd_addr;
	logic                  list_empty;
	logic                  store_full;
	logic                  req_in_store;
	logic [OFFPW-1:0]      off_page;
	logic [PRODW-1:0]      product;
	logic [OFFSET_W-1:0]   offset_sum;
	logic                  mem_we;
	logic [PW-1:0]         mem_addr;
	entry_t                mem_wdata;
	status_t               exec_status;
	logic                  do_pop;
	logic                  do_grow;
	logic                  do_push;
	logic [CW-1:0]         free_nxt;
	logic [CW-1:0]         page_nxt;
	logic [PW-1:0]         head_nxt;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign rd_addr = (mode_t'(mode) == MODE_RELEASE) ? PW'(page_index) : head_q;

	assign list_empty   = (free_cnt_q == '0);
	assign store_full   = (page_cnt_q == MAX_CNT);
	assign req_in_store = (32'(req_s1) < 32'(page_cnt_q));

	always_comb begin
		do_pop      = 1'b0;
		do_grow     = 1'b0;
		do_push     = 1'b0;
		exec_status = ST_OK;
		off_page    = '0;
		mem_addr    = head_q;
		mem_wdata   = '{del: 1'b0, link: head_q};
		if (mode_s1 == MODE_ALLOC) begin
			if (!list_empty) begin
				do_pop    = 1'b1;
				off_page  = OFFPW'(head_q);
				mem_addr  = head_q;
				mem_wdata = '{del: 1'b0, link: rdata_s1.link};
			end else if (!store_full) begin
				do_grow   = 1'b1;
				off_page  = OFFPW'(page_cnt_q);
				mem_addr  = PW'(page_cnt_q);
				mem_wdata = '{del: 1'b0, link: head_q};
			end else begin
				exec_status = ST_NO_SPACE;
			end
		end else begin
			off_page  = OFFPW'(req_s1);
			mem_addr  = PW'(req_s1);
			mem_wdata = '{del: 1'b1, link: head_q};
			if (!req_in_store) begin
				exec_status = ST_NOT_ALLOC;
			end else if (rdata_s1.del) begin
				exec_status = ST_ALREADY;
			end else begin
				do_push = 1'b1;
			end
		end
		mem_we = (state_q == S_EXEC) && (do_pop || do_grow || do_push);
	end

	assign product    = PRODW'(off_page) * PRODW'(page_size_q);
	assign offset_sum = OFFSET_W'(file_hdr_q) + OFFSET_W'(user_hdr_q) + OFFSET_W'(product);

	always_comb begin
		free_nxt = free_cnt_q;
		page_nxt = page_cnt_q;
		head_nxt = head_q;
		if (do_pop) begin
			free_nxt = free_cnt_q - 1'b1;
			head_nxt = rdata_s1.link;
		end
		if (do_grow) begin
			page_nxt = page_cnt_q + 1'b1;
		end
		if (do_push) begin
			free_nxt = free_cnt_q + 1'b1;
			head_nxt = PW'(req_s1);
		end
	end

	// page memory: read at accept, write-back at end of exec
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= mem[rd_addr];
			mode_s1  <= mode_t'(mode);
			req_s1   <= page_index;
		end
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_size_q <= PAGE_SIZE_RST;
			user_hdr_q  <= USER_HDR_RST;
			file_hdr_q  <= FILE_HDR_RST;
			head_q      <= '1;
			free_cnt_q  <= '0;
			page_cnt_q  <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			page_q      <= '0;
			offset_q    <= '0;
			reused_q    <= 1'b0;
			total_q     <= '0;
			freed_q     <= '0;
			live_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_PAGE_SIZE: page_size_q <= PSIZE_W'(cfg_data);
					CFG_USER_HDR:  user_hdr_q  <= UHDR_W'(cfg_data);
					CFG_FILE_HDR:  file_hdr_q  <= FHDR_W'(cfg_data);
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					head_q     <= head_nxt;
					free_cnt_q <= free_nxt;
					page_cnt_q <= page_nxt;
					done_q     <= 1'b1;
					status_q   <= exec_status;
					if (exec_status == ST_NO_SPACE) begin
						page_q   <= '0;
						offset_q <= '0;
					end else begin
						page_q   <= PAGE_IDX_W'(off_page);
						offset_q <= offset_sum;
					end
					reused_q <= do_pop;
					total_q  <= COUNT_W'(page_nxt);
					freed_q  <= COUNT_W'(free_nxt);
					live_q   <= COUNT_W'(page_nxt - free_nxt);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign result_page = page_q;
	assign byte_offset = offset_q;
	assign reused      = reused_q;
	assign total_pages = total_q;
	assign freed_pages = freed_q;
	assign live_pages  = live_q;

endmodule
